// ===== sv/stpc_pkg.sv =====
// ----------------------------------------------------------------------------
// stpc_pkg
// Shared types, constants and helpers for the trim compensation block.
// ----------------------------------------------------------------------------
package stpc_pkg;

    localparam int RAW_W   = 20;
    localparam int TEMP_W  = 15;
    localparam int PRESS_W = 32;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9   = 2'd3;

    localparam logic signed [31:0] TEMP_MIN     = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX     = 32'sd8500;
    localparam logic signed [63:0] TFINE_OFFSET = 64'sd128000;
    localparam logic [63:0]        PRESS_FULL   = 64'd1048576;
    localparam logic [63:0]        PRESS_SCALE  = 64'd3125;
    localparam logic [4:0]         T2_SHIFT     = 5'd11;  // divide by 2048
    localparam logic [4:0]         SQ_SHIFT     = 5'd12;  // divide by 4096
    localparam logic [4:0]         T3_SHIFT     = 5'd14;  // divide by 16384
    localparam logic [4:0]         TEMP_SHIFT   = 5'd8;   // divide by 256

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_trim;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic [RAW_W-1:0] raw_t;
        logic [RAW_W-1:0] raw_p;
    } t_sample;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_TEMP,
        ST_DIV_ISSUE,
        ST_DIV_WAIT,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_TA,
        OP_TB,
        OP_TC,
        OP_XX,
        OP_Y6,
        OP_Y5,
        OP_X3,
        OP_X2,
        OP_X1,
        OP_SCALE,
        OP_P9A,
        OP_P9B,
        OP_P8
    } t_op;

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [31:0] f_sdiv_pow2(input logic signed [31:0] v,
                                                       input logic [4:0] k);
        logic signed [31:0] bias;
        bias = v[31] ? $signed((32'd1 << k) - 32'd1) : 32'sd0;
        return (v + bias) >>> k;
    endfunction

    function automatic logic [63:0] f_sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [63:0] f_sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

endpackage

// ===== sv/stpc_queue.sv =====
// ----------------------------------------------------------------------------
// stpc_queue
// Front end: takes raw samples and holds up to two for the compute engine.
// ----------------------------------------------------------------------------
module stpc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  stpc_pkg::t_sample i_sample,
    output logic              o_avail,
    input  logic              i_pop,
    output stpc_pkg::t_sample o_sample
);
    import stpc_pkg::*;

    t_sample     r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;

    assign o_ready  = (r_count != 2'd2);
    assign o_avail  = (r_count != 2'd0);
    assign push     = i_valid && o_ready;
    assign pop      = i_pop && o_avail;
    assign o_sample = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_sample;
    end

endmodule

// ===== sv/stpc_mul.sv =====
// ----------------------------------------------------------------------------
// stpc_mul
// 64x64 wrapping multiplier built from one 32x32 multiplier over three partial products.
// ----------------------------------------------------------------------------
module stpc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stpc_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic [63:0]        o_prod
);
    import stpc_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] part;

    always_comb begin
        unique case (r_cnt)
            2'd0:    begin op_x = r_a[31:0];  op_y = r_b[31:0];  end
            2'd1:    begin op_x = r_a[31:0];  op_y = r_b[63:32]; end
            default: begin op_x = r_a[63:32]; op_y = r_b[31:0];  end
        endcase
    end

    assign part   = {32'd0, op_x} * {32'd0, op_y};
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            if (r_cnt == 2'd0) r_acc <= part;
            else               r_acc <= r_acc + {part[31:0], 32'd0};
        end
    end

endmodule

// ===== sv/stpc_div.sv =====
// ----------------------------------------------------------------------------
// stpc_div
// 64-bit signed by positive divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stpc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stpc_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [63:0]        o_quot
);
    import stpc_pkg::*;

    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_dvs;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_quot;
    logic [64:0] rem_sh;
    logic [64:0] diff;

    assign rem_sh = {r_rem, r_quo[63]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[63];
            r_quo <= i_req.dividend[63] ? (64'd0 - i_req.dividend) : i_req.dividend;
            r_rem <= 64'd0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!diff[64]) begin
                r_rem <= diff[63:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= rem_sh[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
        if (r_busy && r_cnt == 6'd63) begin
            // last quotient bit folds in here, then sign is restored
            r_quot <= r_neg ? (64'd0 - {r_quo[62:0], ~diff[64]}) : {r_quo[62:0], ~diff[64]};
        end
    end

endmodule

// ===== sv/stpc_core.sv =====
// ----------------------------------------------------------------------------
// stpc_core
// Back end: sequences the compensation steps over the shared mul and div.
// ----------------------------------------------------------------------------
module stpc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  stpc_pkg::t_trim                 i_trim,
    input  logic                            i_avail,
    input  stpc_pkg::t_sample               i_sample,
    output logic                            o_pop,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic signed [stpc_pkg::TEMP_W-1:0] o_temp,
    output logic [stpc_pkg::PRESS_W-1:0]    o_press,
    output logic                            o_invalid
);
    import stpc_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [RAW_W-1:0]        r_adc_t;
    logic [RAW_W-1:0]        r_adc_p;
    logic signed [31:0]      r_ta;
    logic signed [31:0]      r_tb;
    logic signed [31:0]      r_tfine;
    logic signed [TEMP_W-1:0] r_temp;
    logic [63:0] r_x, r_xx, r_y, r_t, r_x1, r_num, r_p, r_m;
    logic [PRESS_W-1:0] r_press;
    logic        r_inval;

    t_mul_req    mul_req;
    t_div_req    div_req;
    logic        mul_start;
    logic        div_start;
    logic        mul_done;
    logic [63:0] mul_prod;
    logic        div_done;
    logic [63:0] div_quot;

    logic [31:0] ta0, tb0, lo32;
    logic [63:0] x1_new;
    logic        x1_bad;
    logic signed [31:0] t5, tq;
    logic [63:0] p_sh;
    logic [63:0] fin_sum;
    logic [63:0] fin_shr;

    stpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    stpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign ta0    = {15'd0, r_adc_t[19:3]} - {15'd0, i_trim.t1, 1'b0};
    assign tb0    = {16'd0, r_adc_t[19:4]} - {16'd0, i_trim.t1};
    assign lo32   = mul_prod[31:0];
    assign x1_new = $signed(mul_prod) >>> 33;
    assign x1_bad = x1_new[63] || (x1_new == 64'd0);
    assign p_sh   = $signed(r_p) >>> 13;
    assign t5     = (r_tfine <<< 2) + r_tfine + 32'sd128;
    assign tq     = f_sdiv_pow2(t5, TEMP_SHIFT);
    assign fin_sum = r_p + r_y + r_t;
    assign fin_shr = $signed(fin_sum) >>> 8;

    // multiplier operands per step
    always_comb begin
        mul_req.start = mul_start;
        mul_req.a = r_x;
        mul_req.b = r_x;
        unique case (r_op)
            OP_TA:    begin mul_req.a = f_sx32(ta0);  mul_req.b = f_sx16(i_trim.t2); end
            OP_TB:    begin mul_req.a = f_sx32(tb0);  mul_req.b = f_sx32(tb0);       end
            OP_TC:    begin mul_req.a = f_sx32(r_tb); mul_req.b = f_sx16(i_trim.t3); end
            OP_XX:    begin mul_req.a = r_x;          mul_req.b = r_x;               end
            OP_Y6:    begin mul_req.a = r_xx;         mul_req.b = f_sx16(i_trim.p6); end
            OP_Y5:    begin mul_req.a = r_x;          mul_req.b = f_sx16(i_trim.p5); end
            OP_X3:    begin mul_req.a = r_xx;         mul_req.b = f_sx16(i_trim.p3); end
            OP_X2:    begin mul_req.a = r_x;          mul_req.b = f_sx16(i_trim.p2); end
            OP_X1:    begin
                mul_req.a = r_t + (64'd1 << 47);
                mul_req.b = {48'd0, i_trim.p1};
            end
            OP_SCALE: begin mul_req.a = r_num;        mul_req.b = PRESS_SCALE;       end
            OP_P9A:   begin mul_req.a = f_sx16(i_trim.p9); mul_req.b = p_sh;         end
            OP_P9B:   begin mul_req.a = r_m;          mul_req.b = p_sh;              end
            OP_P8:    begin mul_req.a = f_sx16(i_trim.p8); mul_req.b = r_p;          end
            default:  begin mul_req.a = r_x;          mul_req.b = r_x;               end
        endcase
    end

    always_comb begin
        div_req.start    = div_start;
        div_req.dividend = r_num;
        div_req.divisor  = r_x1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            ST_IDLE: begin
                if (i_avail) begin
                    n_state = ST_MUL_ISSUE;
                    n_op    = OP_TA;
                end
            end
            ST_MUL_ISSUE: n_state = ST_MUL_WAIT;
            ST_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = ST_MUL_ISSUE;
                    unique case (r_op)
                        OP_TA:    n_op = OP_TB;
                        OP_TB:    n_op = OP_TC;
                        OP_TC:    n_state = ST_TEMP;
                        OP_XX:    n_op = OP_Y6;
                        OP_Y6:    n_op = OP_Y5;
                        OP_Y5:    n_op = OP_X3;
                        OP_X3:    n_op = OP_X2;
                        OP_X2:    n_op = OP_X1;
                        OP_X1: begin
                            if (x1_bad) n_state = ST_OUT;
                            else        n_op = OP_SCALE;
                        end
                        OP_SCALE: n_state = ST_DIV_ISSUE;
                        OP_P9A:   n_op = OP_P9B;
                        OP_P9B:   n_op = OP_P8;
                        OP_P8:    n_state = ST_FINAL;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TEMP: begin
                n_state = ST_MUL_ISSUE;
                n_op    = OP_XX;
            end
            ST_DIV_ISSUE: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_MUL_ISSUE;
                    n_op    = OP_P9A;
                end
            end
            ST_FINAL: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = 1'b0;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:      o_pop = i_avail;
            ST_MUL_ISSUE: mul_start = 1'b1;
            ST_DIV_ISSUE: div_start = 1'b1;
            ST_OUT:       o_res_valid = 1'b1;
            default:      o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_TA;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_avail) begin
            r_adc_t <= i_sample.raw_t;
            r_adc_p <= i_sample.raw_p;
        end
        if (r_state == ST_TEMP) begin
            if (tq < TEMP_MIN)      r_temp <= TEMP_W'(TEMP_MIN);
            else if (tq > TEMP_MAX) r_temp <= TEMP_W'(TEMP_MAX);
            else                    r_temp <= tq[TEMP_W-1:0];
            r_x <= f_sx32(r_tfine) - TFINE_OFFSET;
        end
        if (r_state == ST_DIV_WAIT && div_done) r_p <= div_quot;
        if (r_state == ST_FINAL) begin
            r_press <= PRESS_W'(fin_shr + (f_sx16(i_trim.p7) << 4));
            r_inval <= 1'b0;
        end
        if (r_state == ST_MUL_WAIT && mul_done) begin
            unique case (r_op)
                OP_TA:    r_ta <= f_sdiv_pow2(lo32, T2_SHIFT);
                OP_TB:    r_tb <= f_sdiv_pow2(lo32, SQ_SHIFT);
                OP_TC:    r_tfine <= r_ta + f_sdiv_pow2(lo32, T3_SHIFT);
                OP_XX:    r_xx <= mul_prod;
                OP_Y6:    r_y <= mul_prod;
                OP_Y5:    r_y <= r_y + (mul_prod << 17) + (f_sx16(i_trim.p4) << 35);
                OP_X3:    r_t <= $signed(mul_prod) >>> 8;
                OP_X2:    r_t <= r_t + (mul_prod << 12);
                OP_X1: begin
                    r_x1    <= x1_new;
                    r_num   <= ((PRESS_FULL - {44'd0, r_adc_p}) << 31) - r_y;
                    r_press <= '0;
                    r_inval <= x1_bad;
                end
                OP_SCALE: r_num <= mul_prod;
                OP_P9A:   r_m <= mul_prod;
                OP_P9B:   r_y <= $signed(mul_prod) >>> 25;
                OP_P8:    r_t <= $signed(mul_prod) >>> 19;
                default:  r_m <= r_m;
            endcase
        end
    end

    assign o_temp    = r_temp;
    assign o_press   = r_press;
    assign o_invalid = r_inval;

endmodule

// ===== sv/sensor_temp_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// sensor_temp_pressure_compensation
// Trim compensation of raw temperature and pressure readings.
// ----------------------------------------------------------------------------
// flow: a sample passes the input queue, the core's multiply and divide steps and
//   the output register; the division is skipped when the divisor is flagged
// the core works on one sample at a time, through the 64-step divider and
//   thirteen passes through the shared multiplier
// a two-entry input queue and an output register decouple both sides
// reset: synchronous active low; trim registers clear to 0, queue empties
module sensor_temp_pressure_compensation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stpc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [stpc_pkg::RAW_W-1:0]           i_raw_temperature,
    input  logic [stpc_pkg::RAW_W-1:0]           i_raw_pressure,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [stpc_pkg::TEMP_W-1:0]   o_temperature_centi,
    output logic [stpc_pkg::PRESS_W-1:0]         o_pressure_q24_8,
    output logic                                 o_pressure_invalid
);
    import stpc_pkg::*;

    logic [47:0] r_temp_trim;
    logic [63:0] r_press_low;
    logic [63:0] r_press_high;
    logic [15:0] r_press_p9;

    t_trim   trim;
    t_sample in_sample;
    t_sample q_sample;
    logic    q_avail;
    logic    q_pop;

    logic                     res_valid;
    logic                     res_ready;
    logic signed [TEMP_W-1:0] res_temp;
    logic [PRESS_W-1:0]       res_press;
    logic                     res_inval;

    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic [PRESS_W-1:0]       r_out_press;
    logic                     r_out_inval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim  <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_p9   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_TRIM:  r_temp_trim  <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                CFG_PRESS_HIGH: r_press_high <= i_cfg_data;
                CFG_PRESS_P9:   r_press_p9   <= i_cfg_data[15:0];
                default:        r_press_p9   <= r_press_p9;
            endcase
        end
    end

    assign trim.t1 = r_temp_trim[15:0];
    assign trim.t2 = r_temp_trim[31:16];
    assign trim.t3 = r_temp_trim[47:32];
    assign trim.p1 = r_press_low[15:0];
    assign trim.p2 = r_press_low[31:16];
    assign trim.p3 = r_press_low[47:32];
    assign trim.p4 = r_press_low[63:48];
    assign trim.p5 = r_press_high[15:0];
    assign trim.p6 = r_press_high[31:16];
    assign trim.p7 = r_press_high[47:32];
    assign trim.p8 = r_press_high[63:48];
    assign trim.p9 = r_press_p9;

    assign in_sample.raw_t = i_raw_temperature;
    assign in_sample.raw_p = i_raw_pressure;

    stpc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_sample (in_sample),
        .o_avail  (q_avail),
        .i_pop    (q_pop),
        .o_sample (q_sample)
    );

    stpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_trim      (trim),
        .i_avail     (q_avail),
        .i_sample    (q_sample),
        .o_pop       (q_pop),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_temp      (res_temp),
        .o_press     (res_press),
        .o_invalid   (res_inval)
    );

    // output register, loads when empty or being drained by a transfer
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_temp  <= res_temp;
            r_out_press <= res_press;
            r_out_inval <= res_inval;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_temperature_centi = r_out_temp;
    assign o_pressure_q24_8    = r_out_press;
    assign o_pressure_invalid  = r_out_inval;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_q24_8 == '0)
        else $error("invalid pressure result carries nonzero value");

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_temperature_centi >= -15'sd4000 && o_temperature_centi <= 15'sd8500))
        else $error("temperature outside clamp range");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output register dropped a stalled result");
`endif

endmodule
